@@ hw/rtl/dependence_aware_cluster_steering_assert.svh @@
// assertion macros shared by the steering rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef DEPENDENCE_AWARE_CLUSTER_STEERING_ASSERT_SVH
`define DEPENDENCE_AWARE_CLUSTER_STEERING_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DACS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DACS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dacs_pkg.sv @@
// types and constants for the dependence-aware cluster steering block
// no dependencies; imported by the top-level steering module
`timescale 1ns / 1ps

package dacs_pkg;

  // default sizing
  localparam int NUM_TYPES_DEF    = 16;
  localparam int MAX_SLOTS_DEF    = 4;
  localparam int NUM_CLUSTERS_DEF = 4;
  localparam int NUM_REGS_DEF     = 128;
  localparam int READY_BITS_DEF   = 8;

  // fixed field widths
  localparam int TYPE_W        = 4;
  localparam int REG_W         = 7;
  localparam int SPACE_W       = 4;
  localparam int READY_W       = 32;
  localparam int CID_W         = 2;
  localparam int RCNT_W        = 2;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int COUNT_FIELD_W = 4;
  localparam int CFG_WORD_TYPES = 8;

  localparam logic [CFG_W-1:0] SLOT_COUNTS_RESET = 64'h1111_1111_1111_1111;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_HIGH = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0]  op_type;
    logic [REG_W-1:0]   src_one;
    logic [REG_W-1:0]   src_two;
    logic [REG_W-1:0]   dst_one;
    logic [REG_W-1:0]   dst_two;
    logic [SPACE_W-1:0] cluster_space;
    logic [READY_W-1:0] cluster_ready;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        chosen_slot;
    logic [CID_W-1:0]  chosen_cluster;
    logic [RCNT_W-1:0] remote_operands;
  } out_item_t;

endpackage

@@ hw/rtl/dependence_aware_cluster_steering.sv @@
// top level of the dependence-aware cluster steering block
// depends on dacs_pkg, dacs_ram and dependence_aware_cluster_steering_assert.svh
`timescale 1ns / 1ps
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  cfg      | cfg_wr_en, cfg_index, cfg_data       | in, write only
//  in       | in_valid, in_ready, in_data          | in
//  out      | out_valid, out_ready, out_data       | out
//
//  one beat per cycle sustained while the output is not stalled; a result goes
//  from the pick stage regs (read of the producer rams) to the output reg (pick + write)
//  the producer table is two rams (one per destination) with a per-register
//  valid bit and bank bit in flops, so reset clears it at once, no sweep
//  a same-register read right behind a write is served by a forward path
//  a stalled output holds the pick stage; input stalls only when both are full
//

`include "dependence_aware_cluster_steering_assert.svh"

module dependence_aware_cluster_steering
  import dacs_pkg::*;
#(
  parameter int NUM_TYPES    = NUM_TYPES_DEF,
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
  parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF,
  parameter int NUM_REGS     = NUM_REGS_DEF,
  parameter int READY_BITS   = READY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W = $clog2(NUM_REGS);
  localparam int POS_W  = 9;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] slot_counts;
  logic [CFG_W-1:0] slot_cluster_low;
  logic [CFG_W-1:0] slot_cluster_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counts       <= SLOT_COUNTS_RESET;
      slot_cluster_low  <= '0;
      slot_cluster_high <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SLOT_COUNTS:  slot_counts       <= cfg_data;
        CFG_CLUSTER_LOW:  slot_cluster_low  <= cfg_data;
        CFG_CLUSTER_HIGH: slot_cluster_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- helpers
  // op type modulo NUM_TYPES, as a small table over the 4-bit code
  function automatic logic [TYPE_W-1:0] type_wrap(input logic [TYPE_W-1:0] op);
    logic [TYPE_W-1:0] r;
    r = '0;
    for (int k = 0; k < 2**TYPE_W; k++) begin
      if (op == TYPE_W'(k)) r = TYPE_W'(k % NUM_TYPES);
    end
    return r;
  endfunction

  // cluster id modulo NUM_CLUSTERS, as a small table over the 2-bit id
  function automatic logic [CID_W-1:0] cid_wrap(input logic [CID_W-1:0] id);
    logic [CID_W-1:0] r;
    r = '0;
    for (int k = 0; k < 2**CID_W; k++) begin
      if (id == CID_W'(k)) r = CID_W'(k % NUM_CLUSTERS);
    end
    return r;
  endfunction

  // slots of a type: zero reads as one, clamped to the pool size
  function automatic logic [CNT_W-1:0] count_of(input logic [TYPE_W-1:0] t,
                                                input logic [CFG_W-1:0] counts);
    logic [COUNT_FIELD_W-1:0] f;
    logic [CNT_W-1:0]         n;
    f = counts[t*COUNT_FIELD_W +: COUNT_FIELD_W];
    if (f == '0) n = CNT_W'(1);
    else if (f > MAX_SLOTS) n = CNT_W'(MAX_SLOTS);
    else n = CNT_W'(f);
    return n;
  endfunction

  // cluster owning slot s of type t; fields past bit 63 read as cluster 0
  function automatic logic [CID_W-1:0] cluster_of(input logic [TYPE_W-1:0] t,
                                                  input int s,
                                                  input logic [CFG_W-1:0] lo,
                                                  input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] word;
    logic [POS_W-1:0] pos;
    logic [CID_W-1:0] id;
    word = t[3] ? hi : lo;
    pos  = POS_W'(CID_W * (int'(t[2:0]) * MAX_SLOTS + s));
    id   = '0;
    if (pos < CFG_W) id = word[pos[5:0] +: CID_W];
    return cid_wrap(id);
  endfunction

  // ---------------------------------------------------------------- accept
  logic in_fire;
  logic s1_valid;
  logic s1_fire;

  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  logic [TYPE_W-1:0] t0;
  logic [TIDX_W-1:0] ridx0;
  logic [CNT_W-1:0]  n0;
  logic [CNT_W-1:0]  rr_cur;
  logic [CNT_W-1:0]  rr_next;
  logic [SLOT_W-1:0] start0;
  logic              src_ok0 [2];
  logic              dst_ok0 [2];
  logic [ADDR_W-1:0] src_addr0 [2];
  logic [ADDR_W-1:0] dst_addr0 [2];

  logic [CNT_W-1:0]  rr_pointer [NUM_TYPES];

  // round-robin start: a stale pointer at or past the count restarts at slot 0
  always_comb begin
    t0     = type_wrap(in_data.op_type);
    ridx0  = TIDX_W'(t0);
    n0     = count_of(t0, slot_counts);
    rr_cur = rr_pointer[ridx0];
    if (rr_cur >= n0) begin
      start0  = '0;
      rr_next = CNT_W'(1);
    end else begin
      start0  = SLOT_W'(rr_cur);
      rr_next = rr_cur + CNT_W'(1);
    end
    src_ok0[0]   = (in_data.src_one != '0) && (in_data.src_one < NUM_REGS);
    src_ok0[1]   = (in_data.src_two != '0) && (in_data.src_two < NUM_REGS);
    dst_ok0[0]   = (in_data.dst_one != '0) && (in_data.dst_one < NUM_REGS);
    dst_ok0[1]   = (in_data.dst_two != '0) && (in_data.dst_two < NUM_REGS);
    src_addr0[0] = ADDR_W'(in_data.src_one);
    src_addr0[1] = ADDR_W'(in_data.src_two);
    dst_addr0[0] = ADDR_W'(in_data.dst_one);
    dst_addr0[1] = ADDR_W'(in_data.dst_two);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TYPES; k++) rr_pointer[k] <= '0;
    end else if (in_fire) begin
      rr_pointer[ridx0] <= rr_next;
    end
  end

  // ---------------------------------------------------------------- pick stage regs
  logic [TYPE_W-1:0]  s1_t;
  logic [CNT_W-1:0]   s1_n;
  logic [SLOT_W-1:0]  s1_start;
  logic               s1_src_ok [2];
  logic [ADDR_W-1:0]  s1_src_addr [2];
  logic               s1_dst_ok [2];
  logic [ADDR_W-1:0]  s1_dst_addr [2];
  logic [SPACE_W-1:0] s1_space;
  logic [READY_W-1:0] s1_ready;
  logic               s1_fwd_hit [2];
  logic [CID_W-1:0]   s1_fwd_cid [2];

  logic [SLOT_W-1:0]  pick_slot;
  logic [CID_W-1:0]   pick_cid;
  logic [RCNT_W-1:0]  pick_rem;

  // forward: a source that the item now leaving writes was read stale
  logic               fwd_hit0 [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      fwd_hit0[k] = s1_fire && src_ok0[k] &&
                    ((s1_dst_ok[0] && (s1_dst_addr[0] == src_addr0[k])) ||
                     (s1_dst_ok[1] && (s1_dst_addr[1] == src_addr0[k])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_t     <= t0;
      s1_n     <= n0;
      s1_start <= start0;
      s1_space <= in_data.cluster_space;
      s1_ready <= in_data.cluster_ready;
      for (int k = 0; k < 2; k++) begin
        s1_src_ok[k]   <= src_ok0[k];
        s1_src_addr[k] <= src_addr0[k];
        s1_dst_ok[k]   <= dst_ok0[k];
        s1_dst_addr[k] <= dst_addr0[k];
        s1_fwd_hit[k]  <= fwd_hit0[k];
        s1_fwd_cid[k]  <= pick_cid;
      end
    end
  end

  // ---------------------------------------------------------------- producer table
  // bank 0 takes the first destination, bank 1 the second; a flop per
  // register says which bank holds its latest producer
  logic [CID_W-1:0] b0_rd [2];
  logic [CID_W-1:0] b1_rd [2];
  logic             prod_valid [NUM_REGS];
  logic             prod_bank  [NUM_REGS];
  logic             s1_prod_valid [2];
  logic             s1_prod_bank  [2];

  dacs_ram #(
    .WIDTH (CID_W),
    .DEPTH (NUM_REGS)
  ) u_bank0 (
    .clk     (clk),
    .we      (s1_fire && s1_dst_ok[0]),
    .waddr   (s1_dst_addr[0]),
    .wdata   (pick_cid),
    .re      (in_fire),
    .raddr_a (src_addr0[0]),
    .raddr_b (src_addr0[1]),
    .rdata_a (b0_rd[0]),
    .rdata_b (b0_rd[1])
  );

  dacs_ram #(
    .WIDTH (CID_W),
    .DEPTH (NUM_REGS)
  ) u_bank1 (
    .clk     (clk),
    .we      (s1_fire && s1_dst_ok[1]),
    .waddr   (s1_dst_addr[1]),
    .wdata   (pick_cid),
    .re      (in_fire),
    .raddr_a (src_addr0[0]),
    .raddr_b (src_addr0[1]),
    .rdata_a (b1_rd[0]),
    .rdata_b (b1_rd[1])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) prod_valid[k] <= 1'b0;
    end else if (s1_fire) begin
      if (s1_dst_ok[0]) prod_valid[s1_dst_addr[0]] <= 1'b1;
      if (s1_dst_ok[1]) prod_valid[s1_dst_addr[1]] <= 1'b1;
    end
  end

  // second destination written last so it wins when both name one register
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_dst_ok[0]) prod_bank[s1_dst_addr[0]] <= 1'b0;
      if (s1_dst_ok[1]) prod_bank[s1_dst_addr[1]] <= 1'b1;
    end
  end

  // valid and bank bits read at the same edge as the rams
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < 2; k++) begin
        s1_prod_valid[k] <= prod_valid[src_addr0[k]];
        s1_prod_bank[k]  <= prod_bank[src_addr0[k]];
      end
    end
  end

  // ---------------------------------------------------------------- pick
  logic                  pv [2];
  logic [CID_W-1:0]      pc [2];
  logic [CID_W-1:0]      slot_cid [MAX_SLOTS];
  logic [RCNT_W-1:0]     slot_rem [MAX_SLOTS];
  logic [READY_BITS-1:0] slot_rdy [MAX_SLOTS];
  logic                  slot_ok  [MAX_SLOTS];
  logic [READY_BITS-1:0] best_rdy;
  logic [SLOT_W:0]       scan_idx;
  logic [SLOT_W-1:0]     scan_slot;
  logic [5:0]            rdy_pos;

  always_comb begin
    // producer of each source: forward, else valid bit plus bank select
    for (int k = 0; k < 2; k++) begin
      pv[k] = s1_src_ok[k] && (s1_fwd_hit[k] || s1_prod_valid[k]);
      if (s1_fwd_hit[k]) pc[k] = s1_fwd_cid[k];
      else if (s1_prod_bank[k]) pc[k] = b1_rd[k];
      else pc[k] = b0_rd[k];
    end

    // per-slot cluster, remote count, ready count and eligibility
    for (int s = 0; s < MAX_SLOTS; s++) begin
      slot_cid[s] = cluster_of(s1_t, s, slot_cluster_low, slot_cluster_high);
      slot_rem[s] = RCNT_W'(pv[0] && (pc[0] != slot_cid[s])) +
                    RCNT_W'(pv[1] && (pc[1] != slot_cid[s]));
      rdy_pos     = 6'(int'(slot_cid[s]) * READY_BITS);
      slot_rdy[s] = (rdy_pos < READY_W) ? READY_BITS'(s1_ready >> rdy_pos) : '0;
      slot_ok[s]  = (s < s1_n) && s1_space[slot_cid[s]];
    end

    // the start slot is the fallback; scan in round-robin order and take
    // a strictly better (remote, ready) pair
    pick_slot = s1_start;
    pick_cid  = slot_cid[s1_start];
    pick_rem  = slot_rem[s1_start];
    best_rdy  = slot_rdy[s1_start];
    scan_idx  = '0;
    scan_slot = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      scan_idx = (SLOT_W + 1)'(s1_start) + (SLOT_W + 1)'(i);
      if (scan_idx >= s1_n) scan_idx = scan_idx - (SLOT_W + 1)'(s1_n);
      scan_slot = scan_idx[SLOT_W-1:0];
      if ((i < s1_n) && slot_ok[scan_slot] &&
          (((slot_rem[scan_slot] == pick_rem) && (slot_rdy[scan_slot] < best_rdy)) ||
           (slot_rem[scan_slot] < pick_rem))) begin
        pick_slot = scan_slot;
        pick_cid  = slot_cid[scan_slot];
        pick_rem  = slot_rem[scan_slot];
        best_rdy  = slot_rdy[scan_slot];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  out_item_t out_reg;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign out_data = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_reg.chosen_slot     <= 2'(pick_slot);
      out_reg.chosen_cluster  <= pick_cid;
      out_reg.remote_operands <= pick_rem;
    end
  end

  // ---------------------------------------------------------------- checks
  `DACS_ASSERT_NEXT(a_pick_stage_holds, clk, rst, s1_valid && !s1_fire, s1_valid && $stable(s1_start), "stalled pick stage lost its item")
  `DACS_ASSERT_NOW(a_pick_in_pool, clk, rst, s1_valid, pick_slot < s1_n, "picked slot outside the type pool")
  `DACS_ASSERT_NOW(a_pick_has_space, clk, rst, s1_valid && (pick_slot != s1_start), s1_space[pick_cid], "moved off start slot into a full cluster")
  `DACS_ASSERT_NEXT(a_rr_advanced, clk, rst, in_fire, rr_pointer[$past(ridx0)] != '0, "round-robin pointer not advanced")

endmodule

@@ hw/rtl/dacs_ram.sv @@
// generic synchronous ram: one write port, two registered read ports
// standalone, no package dependency
`timescale 1ns / 1ps

module dacs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                     rdata_a,
  output logic [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
